// ===== src/etb_pkg.sv =====
// shared types and constants for the escaped text to bytes decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package etb_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FIFO_DEPTH     = 2;
    localparam int CHAR_W         = 8;
    localparam int OUT_CNT_W      = 16;
    localparam int ADDR_W         = 2;

    localparam logic [ADDR_W-1:0]    ADDR_MAX_BYTES = 2'd0;
    localparam logic [OUT_CNT_W-1:0] MAX_BYTES_RST  = 16'd256;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] BYTE_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] BYTE_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] BYTE_BS   = 8'h08;
    localparam logic [CHAR_W-1:0] BYTE_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0] BYTE_BAD  = 8'hFF;

    // one queue entry: one or two data beats, or an end-of-text beat
    typedef struct packed {
        logic                 kind;
        logic                 two;
        logic [CHAR_W-1:0]    byte0;
        logic [CHAR_W-1:0]    byte1;
        logic [OUT_CNT_W-1:0] count;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/escaped_text_to_bytes.sv =====
// escaped text decoder top level: one text character per beat in, raw byte beats out
// a result beat is registered first in the queue and then in the output register, which
// loads when it is free
// throughput: one character per cycle while the queue is not full; a two-byte escape holds
// the output for a second beat, absorbed by a two-entry queue between front and back
// reset: asynchronous active-low rst_n clears parser, count and queue; max_bytes returns to 256
// depends on etb_pkg, etb_front, etb_fifo, etb_back
`timescale 1ns / 1ps
`default_nettype none

module escaped_text_to_bytes #(
    parameter int COUNT_BITS = etb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          text_valid,
    output logic                               text_stall,
    input  wire logic [etb_pkg::CHAR_W-1:0]    text_char,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               result_kind,
    output logic [etb_pkg::CHAR_W-1:0]         data_byte,
    output logic [etb_pkg::OUT_CNT_W-1:0]      byte_count,
    output logic                               last_of_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [etb_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import etb_pkg::*;

    logic [OUT_CNT_W-1:0] max_bytes_reg;
    logic                 q_push, q_pop, q_full, q_empty;
    entry_t               q_wr, q_rd;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_BYTES) ? {16'd0, max_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BYTES)
        begin
            max_bytes_reg <= pwdata[OUT_CNT_W-1:0];
        end
    end

    etb_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_char  (text_char),
        .text_stall (text_stall),
        .max_bytes  (max_bytes_reg),
        .fifo_full  (q_full),
        .push       (q_push),
        .entry      (q_wr)
    );

    etb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr),
        .pop      (q_pop),
        .rd_entry (q_rd),
        .full     (q_full),
        .empty    (q_empty)
    );

    etb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_entry     (q_rd),
        .empty        (q_empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .data_byte    (data_byte),
        .byte_count   (byte_count),
        .last_of_item (last_of_item)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_END |-> last_of_item && data_byte == 8'h00)
        else $error("end-of-text beat malformed");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_DATA |->
            byte_count != '0 && byte_count <= max_bytes_reg)
        else $error("data beat count outside limit");

endmodule

`default_nettype wire

// ===== src/etb_front.sv =====
// front part: accepts text characters, parses escapes and applies the byte limit
// depends on etb_pkg
`timescale 1ns / 1ps
`default_nettype none

module etb_front #(
    parameter int COUNT_BITS = etb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           text_valid,
    input  wire logic [etb_pkg::CHAR_W-1:0]     text_char,
    output logic                                text_stall,
    input  wire logic [etb_pkg::OUT_CNT_W-1:0]  max_bytes,
    input  wire logic                           fifo_full,
    output logic                                push,
    output etb_pkg::entry_t                     entry
);
    import etb_pkg::*;

    localparam int CNT_W = (COUNT_BITS < OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_HEX2  = 2'd3
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [3:0]       nibble_reg, nibble_next;
    logic             bad_reg, bad_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             fire;
    logic [CNT_W-1:0] cap;
    logic             room1, room2;
    logic [1:0]       n_emit;
    logic [CHAR_W-1:0] b0, b1;
    logic [4:0]       hv;

    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    assign text_stall = fifo_full;
    assign fire       = text_valid && !fifo_full;
    assign cap        = (max_bytes >= OUT_CNT_W'(CNT_TOP)) ? CNT_TOP : CNT_W'(max_bytes);
    assign room1      = cnt_reg < cap;
    assign room2      = ({1'b0, cnt_reg} + (CNT_W+1)'(1)) < {1'b0, cap};
    assign hv         = hex_decode(text_char);

    always_comb
    begin
        mode_next   = mode_reg;
        nibble_next = nibble_reg;
        bad_next    = bad_reg;
        cnt_next    = cnt_reg;
        n_emit      = 2'd0;
        b0          = text_char;
        b1          = text_char;
        push        = 1'b0;
        entry       = '0;
        if (fire)
        begin
            if (text_char == CH_NUL)
            begin
                push        = 1'b1;
                entry.kind  = KIND_END;
                entry.count = OUT_CNT_W'(cnt_reg);
                mode_next   = MODE_PLAIN;
                nibble_next = 4'd0;
                bad_next    = 1'b0;
                cnt_next    = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_PLAIN:
                    begin
                        if (text_char == CH_BSLASH) mode_next = MODE_ESC;
                        else n_emit = 2'd1;
                    end
                    MODE_ESC:
                    begin
                        mode_next = MODE_PLAIN;
                        n_emit    = 2'd1;
                        unique case (text_char)
                            CH_N:      b0 = BYTE_LF;
                            CH_R:      b0 = BYTE_CR;
                            CH_B:      b0 = BYTE_BS;
                            CH_T:      b0 = BYTE_TAB;
                            CH_DQUOTE: b0 = CH_DQUOTE;
                            CH_SQUOTE: b0 = CH_SQUOTE;
                            CH_X:
                            begin
                                n_emit    = 2'd0;
                                mode_next = MODE_HEX1;
                            end
                            default:
                            begin
                                n_emit = 2'd2;
                                b0     = CH_BSLASH;
                            end
                        endcase
                    end
                    MODE_HEX1:
                    begin
                        bad_next    = !hv[4];
                        nibble_next = hv[4] ? hv[3:0] : 4'd0;
                        mode_next   = MODE_HEX2;
                    end
                    MODE_HEX2:
                    begin
                        n_emit      = 2'd1;
                        b0          = (!hv[4] || bad_reg) ? BYTE_BAD : {nibble_reg, hv[3:0]};
                        mode_next   = MODE_PLAIN;
                        nibble_next = 4'd0;
                        bad_next    = 1'b0;
                    end
                endcase
                if (n_emit != 2'd0 && room1)
                begin
                    push        = 1'b1;
                    entry.kind  = KIND_DATA;
                    entry.byte0 = b0;
                    entry.byte1 = b1;
                    entry.two   = (n_emit == 2'd2) && room2;
                    entry.count = OUT_CNT_W'(cnt_reg) + OUT_CNT_W'(1);
                    cnt_next    = cnt_reg + (entry.two ? CNT_W'(2) : CNT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            nibble_reg <= 4'd0;
            bad_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
            bad_reg    <= bad_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/etb_fifo.sv =====
// short queue of decoded entries between front and back
// depends on etb_pkg
`timescale 1ns / 1ps
`default_nettype none

module etb_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire etb_pkg::entry_t wr_entry,
    input  wire logic            pop,
    output etb_pkg::entry_t      rd_entry,
    output logic                 full,
    output logic                 empty
);
    import etb_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    entry_t           slots [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = level_reg == LVL_W'(FIFO_DEPTH);
    assign empty    = level_reg == '0;
    assign rd_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) slots[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/etb_back.sv =====
// back part: splits queue entries into result beats behind an output register
// depends on etb_pkg
`timescale 1ns / 1ps
`default_nettype none

module etb_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire etb_pkg::entry_t               rd_entry,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               result_kind,
    output logic [etb_pkg::CHAR_W-1:0]         data_byte,
    output logic [etb_pkg::OUT_CNT_W-1:0]      byte_count,
    output logic                               last_of_item
);
    import etb_pkg::*;

    logic                 valid_reg;
    logic                 pend_reg;
    logic                 kind_reg;
    logic [CHAR_W-1:0]    byte_reg;
    logic [CHAR_W-1:0]    byte1_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic                 last_reg;
    logic                 load;

    assign load         = !valid_reg || !result_stall;
    assign pop          = load && !pend_reg && !empty;
    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign data_byte    = byte_reg;
    assign byte_count   = count_reg;
    assign last_of_item = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= pend_reg || !empty;
            pend_reg  <= !pend_reg && !empty && rd_entry.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                kind_reg  <= KIND_DATA;
                byte_reg  <= byte1_reg;
                count_reg <= count_reg + OUT_CNT_W'(1);
                last_reg  <= 1'b1;
            end
            else if (!empty)
            begin
                kind_reg  <= rd_entry.kind;
                byte_reg  <= rd_entry.byte0;
                byte1_reg <= rd_entry.byte1;
                count_reg <= rd_entry.count;
                last_reg  <= !rd_entry.two;
            end
        end
    end

endmodule

`default_nettype wire
